### hdl/brbw_pkg.sv
// ----------------------------------------------------------------------------
// brbw_pkg
// Shared widths, operation codes and controller/datapath interface types
// for the byte ring buffer with word push.
// ----------------------------------------------------------------------------
package brbw_pkg;

  localparam int OP_W       = 3;
  localparam int WORD_W     = 32;
  localparam int COUNT_W    = 12;
  localparam int WORD_BYTES = 4;

  localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [OP_W-1:0] OP_CONSUME = 3'd1;
  localparam logic [OP_W-1:0] OP_PRODUCE = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic       reduce;
    logic       wr_en;
    logic       update;
    logic       result;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic push_ok;
  } sts_t;

endpackage

### hdl/byte_ring_buffer_word_push.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_word_push
// Byte-addressed ring buffer with one slot kept free: push a 32-bit word,
// advance read or write pointer by a count, clear, or query.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy then stays high
// until the result is ready. The sequence is set by the byte store, with one
// read port and one write port, which reads the four head bytes and writes
// the four pushed bytes one per cycle (the write only for a push that is
// stored), and by the pointer wrap of a count, which is reduced one
// compare-subtract step per cycle over N steps, where
// N = clog2((BUFFER_BYTES + 4094) / BUFFER_BYTES + 1) (N = 1 for 4096 bytes).
// The pointers are then updated and the result registered. The result sits
// on the out_ ports for exactly one cycle while out_valid is high and cannot
// be held off; busy is already low in that cycle, so the next word may be
// started then.
module byte_ring_buffer_word_push #(
  parameter int BUFFER_BYTES = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [brbw_pkg::OP_W-1:0]    in_op,
  input  logic [brbw_pkg::WORD_W-1:0]  in_push_word,
  input  logic [brbw_pkg::COUNT_W-1:0] in_byte_count,
  output logic                         out_valid,
  output logic                         out_status,
  output logic [brbw_pkg::WORD_W-1:0]  out_head_word,
  output logic [brbw_pkg::COUNT_W-1:0] out_free_bytes,
  output logic [brbw_pkg::COUNT_W-1:0] out_contiguous_free,
  output logic [brbw_pkg::COUNT_W-1:0] out_used_bytes,
  output logic [brbw_pkg::COUNT_W-1:0] out_contiguous_used
);

  localparam int QMAX      = (BUFFER_BYTES + (1 << brbw_pkg::COUNT_W) - 2) / BUFFER_BYTES;
  localparam int RED_STEPS = $clog2(QMAX + 1);

  brbw_pkg::cmd_t cmd;
  brbw_pkg::sts_t sts;

  brbw_ctrl #(
    .RED_STEPS (RED_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  brbw_dp #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .RED_STEPS    (RED_STEPS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_op               (in_op),
    .in_push_word        (in_push_word),
    .in_byte_count       (in_byte_count),
    .out_status          (out_status),
    .out_head_word       (out_head_word),
    .out_free_bytes      (out_free_bytes),
    .out_contiguous_free (out_contiguous_free),
    .out_used_bytes      (out_used_bytes),
    .out_contiguous_used (out_contiguous_used)
  );

endmodule

### hdl/brbw_ram.sv
// ----------------------------------------------------------------------------
// brbw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brbw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/brbw_ctrl.sv
// ----------------------------------------------------------------------------
// brbw_ctrl
// Sequencer: head read, count reduction, push write, pointer update, result.
// ----------------------------------------------------------------------------
module brbw_ctrl #(
  parameter int RED_STEPS = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           out_valid,
  output brbw_pkg::cmd_t cmd,
  input  brbw_pkg::sts_t sts
);

  localparam int CNT_MAX = (RED_STEPS > brbw_pkg::WORD_BYTES) ?
                           RED_STEPS : brbw_pkg::WORD_BYTES;
  localparam int CNTW    = (CNT_MAX > 2) ? $clog2(CNT_MAX) : 1;

  localparam logic [CNTW-1:0] LAST_BYTE = CNTW'(brbw_pkg::WORD_BYTES - 1);
  localparam logic [CNTW-1:0] LAST_RED  = CNTW'(RED_STEPS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_RWAIT  = 3'd2;
  localparam logic [2:0] S_REDUCE = 3'd3;
  localparam logic [2:0] S_WRITE  = 3'd4;
  localparam logic [2:0] S_UPDATE = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0]      state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.idx   = cnt_r[1:0];
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        if (cnt_r == LAST_BYTE) begin
          cnt_nxt   = '0;
          state_nxt = S_RWAIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RWAIT: begin
        state_nxt = S_REDUCE;
      end
      S_REDUCE: begin
        cmd.reduce = 1'b1;
        if (cnt_r == LAST_RED) begin
          cnt_nxt   = '0;
          state_nxt = sts.push_ok ? S_WRITE : S_UPDATE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_WRITE: begin
        cmd.wr_en = 1'b1;
        if (cnt_r == LAST_BYTE) begin
          cnt_nxt   = '0;
          state_nxt = S_UPDATE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        cmd.result = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= (state_r == S_RESULT);
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not start the sequence");

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while sequence still running");

  a_valid_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> sts.push_ok)
    else $error("byte write without an accepted push");

endmodule

### hdl/brbw_dp.sv
// ----------------------------------------------------------------------------
// brbw_dp
// Datapath: pointers, byte store, head word capture, count reduction and
// free/used space results.
// ----------------------------------------------------------------------------
module brbw_dp #(
  parameter int BUFFER_BYTES = 4096,
  parameter int RED_STEPS    = 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  brbw_pkg::cmd_t                       cmd,
  output brbw_pkg::sts_t                       sts,
  input  logic [brbw_pkg::OP_W-1:0]            in_op,
  input  logic [brbw_pkg::WORD_W-1:0]          in_push_word,
  input  logic [brbw_pkg::COUNT_W-1:0]         in_byte_count,
  output logic                                 out_status,
  output logic [brbw_pkg::WORD_W-1:0]          out_head_word,
  output logic [brbw_pkg::COUNT_W-1:0]         out_free_bytes,
  output logic [brbw_pkg::COUNT_W-1:0]         out_contiguous_free,
  output logic [brbw_pkg::COUNT_W-1:0]         out_used_bytes,
  output logic [brbw_pkg::COUNT_W-1:0]         out_contiguous_used
);

  localparam int PW = $clog2(BUFFER_BYTES);
  localparam int XW = $clog2(BUFFER_BYTES + (1 << brbw_pkg::COUNT_W) - 1);
  localparam int TW = XW + RED_STEPS;

  localparam logic [PW:0]   BB1      = (PW+1)'(BUFFER_BYTES);
  localparam logic [PW-1:0] CAP      = PW'(BUFFER_BYTES - 1);
  localparam logic [PW-1:0] WB       = PW'(brbw_pkg::WORD_BYTES);
  localparam logic [2:0]    WB3      = 3'(brbw_pkg::WORD_BYTES);
  localparam logic [TW-1:0] THR_INIT = TW'(BUFFER_BYTES * (2 ** (RED_STEPS - 1)));

  function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] p, logic [2:0] n);
    logic [PW:0] s;
    s = {1'b0, p} + (PW+1)'(n);
    if (s >= BB1) begin
      s = s - BB1;
    end
    return s[PW-1:0];
  endfunction

  logic [brbw_pkg::OP_W-1:0]   op_r;
  logic [brbw_pkg::WORD_W-1:0] word_r;
  logic [XW-1:0]               x_r;
  logic [TW-1:0]               thr_r;
  logic [PW-1:0]               rd_ptr_r, wr_ptr_r;
  logic [PW-1:0]               rd_ptr_nxt, wr_ptr_nxt;
  logic [brbw_pkg::WORD_W-1:0] head_r;
  logic                        cap_r;
  logic                        status_r;
  logic [brbw_pkg::COUNT_W-1:0] free_r, cfree_r, used_r, cused_r;

  logic [PW-1:0] free_now, cfree_now;
  logic          push_ok;
  logic [PW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  always_comb begin
    if (wr_ptr_r >= rd_ptr_r) begin
      free_now = CAP - (wr_ptr_r - rd_ptr_r);
      if (rd_ptr_r == '0) begin
        cfree_now = CAP - wr_ptr_r;
      end else begin
        cfree_now = PW'(BB1 - {1'b0, wr_ptr_r});
      end
    end else begin
      free_now  = rd_ptr_r - wr_ptr_r - 1'b1;
      cfree_now = rd_ptr_r - wr_ptr_r - 1'b1;
    end
  end

  assign push_ok     = (op_r == brbw_pkg::OP_PUSH) && (free_now >= WB);
  assign sts.push_ok = push_ok;

  assign ram_raddr = wrap_add(rd_ptr_r, {1'b0, cmd.idx});
  assign ram_waddr = wrap_add(wr_ptr_r, {1'b0, cmd.idx});
  assign ram_wdata = word_r[8*cmd.idx +: 8];

  brbw_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    unique case (op_r)
      brbw_pkg::OP_PUSH: begin
        if (push_ok) begin
          wr_ptr_nxt = wrap_add(wr_ptr_r, WB3);
        end
      end
      brbw_pkg::OP_CONSUME: rd_ptr_nxt = x_r[PW-1:0];
      brbw_pkg::OP_PRODUCE: wr_ptr_nxt = x_r[PW-1:0];
      brbw_pkg::OP_CLEAR: begin
        rd_ptr_nxt = '0;
        wr_ptr_nxt = '0;
      end
      default: begin
        rd_ptr_nxt = rd_ptr_r;
      end
    endcase
    if (rd_ptr_nxt == wr_ptr_nxt) begin
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cap_r    <= 1'b0;
    end else begin
      cap_r <= cmd.rd_en;
      if (cmd.update) begin
        rd_ptr_r <= rd_ptr_nxt;
        wr_ptr_r <= wr_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      word_r <= in_push_word;
      thr_r  <= THR_INIT;
      if (in_op == brbw_pkg::OP_CONSUME) begin
        x_r <= XW'(rd_ptr_r) + XW'(in_byte_count);
      end else begin
        x_r <= XW'(wr_ptr_r) + XW'(in_byte_count);
      end
    end
    if (cmd.reduce) begin
      thr_r <= thr_r >> 1;
      if (TW'(x_r) >= thr_r) begin
        x_r <= XW'(TW'(x_r) - thr_r);
      end
    end
    if (cap_r) begin
      head_r <= {ram_rdata, head_r[brbw_pkg::WORD_W-1:8]};
    end
    if (cmd.update) begin
      status_r <= (op_r == brbw_pkg::OP_PUSH) && !push_ok;
    end
    if (cmd.result) begin
      free_r  <= brbw_pkg::COUNT_W'(free_now);
      cfree_r <= brbw_pkg::COUNT_W'(cfree_now);
      used_r  <= brbw_pkg::COUNT_W'(CAP - free_now);
      cused_r <= brbw_pkg::COUNT_W'(CAP - cfree_now);
    end
  end

  assign out_status          = status_r;
  assign out_head_word       = head_r;
  assign out_free_bytes      = free_r;
  assign out_contiguous_free = cfree_r;
  assign out_used_bytes      = used_r;
  assign out_contiguous_used = cused_r;

endmodule

### dv/ring_buffer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_checker
// Watches the word and result channels of the byte ring buffer. Keeps its
// own copy of the pointers and the byte store, predicts the result of every
// accepted word and compares each result, field by field, with the oldest
// prediction. Head bytes never written since reset are not compared.
// ----------------------------------------------------------------------------
module ring_buffer_checker #(
  parameter int BUFFER_BYTES = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [brbw_pkg::OP_W-1:0]    in_op,
  input  logic [brbw_pkg::WORD_W-1:0]  in_push_word,
  input  logic [brbw_pkg::COUNT_W-1:0] in_byte_count,
  input  logic                         out_valid,
  input  logic                         out_status,
  input  logic [brbw_pkg::WORD_W-1:0]  out_head_word,
  input  logic [brbw_pkg::COUNT_W-1:0] out_free_bytes,
  input  logic [brbw_pkg::COUNT_W-1:0] out_contiguous_free,
  input  logic [brbw_pkg::COUNT_W-1:0] out_used_bytes,
  input  logic [brbw_pkg::COUNT_W-1:0] out_contiguous_used,
  output int                           mismatches,
  output int                           pending_words
);
  import brbw_pkg::*;

  localparam int CAPACITY   = BUFFER_BYTES - 1;
  localparam int MAX_REPORT = 10;

  typedef struct packed {
    logic                  status;
    logic [WORD_W-1:0]     head;
    logic [WORD_BYTES-1:0] head_known;
    logic [COUNT_W-1:0]    free_bytes;
    logic [COUNT_W-1:0]    contig_free;
    logic [COUNT_W-1:0]    used_bytes;
    logic [COUNT_W-1:0]    contig_used;
  } ring_report_t;

  logic [7:0]   byte_mem   [BUFFER_BYTES];
  bit           byte_known [BUFFER_BYTES];
  int           rd_pos = 0;
  int           wr_pos = 0;
  ring_report_t report_q [$];
  int           fail_count = 0;
  int           queued = 0;

  assign mismatches    = fail_count;
  assign pending_words = queued;

  function automatic int free_of(int rp, int wp);
    if (wp >= rp) return CAPACITY - (wp - rp);
    return rp - wp - 1;
  endfunction

  function automatic int contig_free_of(int rp, int wp);
    if (wp >= rp) return (rp == 0) ? CAPACITY - wp : BUFFER_BYTES - wp;
    return rp - wp - 1;
  endfunction

  task automatic apply_ring_op(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word,
                               input logic [COUNT_W-1:0] count);
    ring_report_t rep;
    int           idx;
    int           fr;
    int           cf;
    rep = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      idx = (rd_pos + i) % BUFFER_BYTES;
      rep.head_known[i] = byte_known[idx];
      rep.head[8*i +: 8] = byte_known[idx] ? byte_mem[idx] : 8'hxx;
    end
    case (op)
      OP_PUSH: begin
        if (free_of(rd_pos, wr_pos) < WORD_BYTES) begin
          rep.status = 1'b1;
        end else begin
          for (int i = 0; i < WORD_BYTES; i++) begin
            idx = (wr_pos + i) % BUFFER_BYTES;
            byte_mem[idx]   = word[8*i +: 8];
            byte_known[idx] = 1'b1;
          end
          wr_pos = (wr_pos + WORD_BYTES) % BUFFER_BYTES;
        end
      end
      OP_CONSUME: rd_pos = (rd_pos + int'(count)) % BUFFER_BYTES;
      OP_PRODUCE: wr_pos = (wr_pos + int'(count)) % BUFFER_BYTES;
      OP_CLEAR: begin
        rd_pos = 0;
        wr_pos = 0;
      end
      default: ;
    endcase
    // snap both pointers to zero on empty
    if (rd_pos == wr_pos) begin
      rd_pos = 0;
      wr_pos = 0;
    end
    fr = free_of(rd_pos, wr_pos);
    cf = contig_free_of(rd_pos, wr_pos);
    rep.free_bytes  = COUNT_W'(fr);
    rep.contig_free = COUNT_W'(cf);
    rep.used_bytes  = COUNT_W'(CAPACITY - fr);
    rep.contig_used = COUNT_W'(CAPACITY - cf);
    report_q.push_back(rep);
  endtask

  function automatic bit report_matches(ring_report_t e);
    bit ok;
    ok = (out_status === e.status) && (out_free_bytes === e.free_bytes) &&
         (out_contiguous_free === e.contig_free) && (out_used_bytes === e.used_bytes) &&
         (out_contiguous_used === e.contig_used);
    for (int i = 0; i < WORD_BYTES; i++)
      if (e.head_known[i] && (out_head_word[8*i +: 8] !== e.head[8*i +: 8])) ok = 1'b0;
    return ok;
  endfunction

  always @(posedge clk) begin : watch
    ring_report_t exp_rep;
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) begin
        if (report_q.size() == 0) begin
          if (fail_count < MAX_REPORT)
            $display("%0t: result with no word outstanding: status=%0d head=%h free=%0d",
                     $realtime, out_status, out_head_word, out_free_bytes);
          fail_count = fail_count + 1;
        end else begin
          exp_rep = report_q.pop_front();
          if (!report_matches(exp_rep)) begin
            if (fail_count < MAX_REPORT) begin
              $display("%0t: mismatch exp status=%0d head=%h free=%0d cfree=%0d used=%0d cused=%0d",
                       $realtime, exp_rep.status, exp_rep.head, exp_rep.free_bytes,
                       exp_rep.contig_free, exp_rep.used_bytes, exp_rep.contig_used);
              $display("%0t:          got status=%0d head=%h free=%0d cfree=%0d used=%0d cused=%0d",
                       $realtime, out_status, out_head_word, out_free_bytes,
                       out_contiguous_free, out_used_bytes, out_contiguous_used);
            end
            fail_count = fail_count + 1;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        apply_ring_op(in_op, in_push_word, in_byte_count);
    end
    queued <= report_q.size();
  end

endmodule

### dv/byte_ring_buffer_word_push_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_word_push_test
// Drives the byte ring buffer with a directed run over the corner cases
// (refused push, split push across the wrap, over-consume and over-produce,
// snap to empty, clear, unknown ops) and then a long random word stream
// with random sender gaps and drain-and-align steps; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module byte_ring_buffer_word_push_test;
  import brbw_pkg::*;

  localparam int BUFFER_BYTES = 4096;
  localparam int RANDOM_WORDS = 1200;
  localparam int TAIL_CYCLES  = 24;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic [OP_W-1:0]    in_op = OP_QUERY;
  logic [WORD_W-1:0]  in_push_word = '0;
  logic [COUNT_W-1:0] in_byte_count = '0;
  logic               busy;
  logic               out_valid;
  logic               out_status;
  logic [WORD_W-1:0]  out_head_word;
  logic [COUNT_W-1:0] out_free_bytes;
  logic [COUNT_W-1:0] out_contiguous_free;
  logic [COUNT_W-1:0] out_used_bytes;
  logic [COUNT_W-1:0] out_contiguous_used;
  int                 mismatches;
  int                 pending_words;
  logic [COUNT_W-1:0] last_used = '0;
  logic [COUNT_W-1:0] last_free = '0;
  int                 steady_left = 0;

  always #10 clk = ~clk;

  byte_ring_buffer_word_push #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_push_word        (in_push_word),
    .in_byte_count       (in_byte_count),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_head_word       (out_head_word),
    .out_free_bytes      (out_free_bytes),
    .out_contiguous_free (out_contiguous_free),
    .out_used_bytes      (out_used_bytes),
    .out_contiguous_used (out_contiguous_used)
  );

  ring_buffer_checker #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_push_word        (in_push_word),
    .in_byte_count       (in_byte_count),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_head_word       (out_head_word),
    .out_free_bytes      (out_free_bytes),
    .out_contiguous_free (out_contiguous_free),
    .out_used_bytes      (out_used_bytes),
    .out_contiguous_used (out_contiguous_used),
    .mismatches          (mismatches),
    .pending_words       (pending_words)
  );

  always @(posedge clk) begin
    if (out_valid === 1'b1) begin
      last_used <= out_used_bytes;
      last_free <= out_free_bytes;
    end
  end

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return COUNT_W'(WORD_BYTES * $urandom_range(0, 4));
      5, 6, 7:       return COUNT_W'($urandom_range(0, 16));
      8:             return COUNT_W'($urandom);
      default:       return COUNT_W'($urandom_range(BUFFER_BYTES - 8, BUFFER_BYTES - 1));
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_unknown_op();
    return OP_W'($urandom_range(int'(OP_QUERY) + 1, (1 << OP_W) - 1));
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word,
                           input logic [COUNT_W-1:0] count);
    in_op         <= op;
    in_push_word  <= word;
    in_byte_count <= count;
    start         <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic pause_sender();
    int gap;
    if (steady_left > 0) begin
      steady_left = steady_left - 1;
      return;
    end
    if ($urandom_range(0, 9) < 4) return;
    gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 16) : $urandom_range(30, 80);
    start         <= 1'b0;
    in_op         <= OP_W'($urandom);
    in_push_word  <= $urandom;
    in_byte_count <= COUNT_W'($urandom);
    repeat (gap) @(posedge clk);
  endtask

  task automatic wait_all_reported();
    start <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  initial begin
    int choice;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(OP_QUERY, pick_word(), pick_count());
    send_word(OP_PUSH, 32'h0000_0000, 12'd0);
    send_word(OP_PUSH, 32'hFFFF_FFFF, 12'hFFF);
    send_word(OP_PUSH, 32'hA5C3_0F81, 12'd7);
    send_word(OP_CONSUME, pick_word(), 12'd4);
    send_word(OP_PRODUCE, pick_word(), 12'd0);
    send_word(OP_CONSUME, pick_word(), 12'hFFF);
    send_word(OP_CLEAR, pick_word(), pick_count());
    send_word(OP_PRODUCE, pick_word(), COUNT_W'(BUFFER_BYTES - WORD_BYTES));
    send_word(OP_PUSH, 32'h0BAD_F00D, 12'd0);
    send_word(OP_PRODUCE, pick_word(), 12'd4);
    send_word(OP_PRODUCE, pick_word(), COUNT_W'(BUFFER_BYTES - 2));
    send_word(OP_CONSUME, pick_word(), COUNT_W'(BUFFER_BYTES - 3));
    send_word(OP_PUSH, 32'h1234_5678, 12'd0);
    send_word(OP_PUSH, 32'hDEAD_BEEF, 12'd0);
    send_word(OP_CONSUME, pick_word(), 12'd1);
    send_word(OP_QUERY, pick_word(), pick_count());
    send_word(OP_CONSUME, pick_word(), 12'd4);
    send_word(OP_QUERY, pick_word(), pick_count());
    send_word(OP_CONSUME, pick_word(), 12'd4);
    send_word(OP_QUERY + 3'd1, pick_word(), 12'hFFF);
    send_word(OP_QUERY + 3'd2, pick_word(), pick_count());
    send_word(OP_QUERY + 3'd3, pick_word(), pick_count());
    send_word(OP_PRODUCE, pick_word(), 12'hFFF);
    send_word(OP_PUSH, pick_word(), 12'd0);
    send_word(OP_CONSUME, pick_word(), 12'hFFF);
    wait_all_reported();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(0, 24) == 0) begin
        // drain, then land the pointers exactly on empty, full or one past
        wait_all_reported();
        case ($urandom_range(0, 3))
          0:       send_word(OP_CONSUME, pick_word(), last_used);
          1:       send_word(OP_PRODUCE, pick_word(), last_free);
          2:       send_word(OP_CONSUME, pick_word(), last_used + 1'b1);
          default: send_word(OP_PRODUCE, pick_word(), last_free + 1'b1);
        endcase
      end else begin
        choice = $urandom_range(0, 99);
        if (choice < 42)      send_word(OP_PUSH, pick_word(), pick_count());
        else if (choice < 67) send_word(OP_CONSUME, pick_word(), pick_count());
        else if (choice < 79) send_word(OP_PRODUCE, pick_word(), pick_count());
        else if (choice < 91) send_word(OP_QUERY, pick_word(), pick_count());
        else if (choice < 94) send_word(OP_CLEAR, pick_word(), pick_count());
        else                  send_word(pick_unknown_op(), pick_word(), pick_count());
      end
      if (steady_left == 0 && $urandom_range(0, 19) == 0)
        steady_left = $urandom_range(20, 60);
      pause_sender();
    end

    wait_all_reported();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_words == 0) begin
      $display("byte_ring_buffer_word_push_test: clean");
    end else begin
      $display("byte_ring_buffer_word_push_test: errors");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("byte_ring_buffer_word_push_test: errors");
    $finish;
  end

endmodule

### byte_ring_buffer_word_push.f
hdl/brbw_pkg.sv
hdl/brbw_ram.sv
hdl/brbw_ctrl.sv
hdl/brbw_dp.sv
hdl/byte_ring_buffer_word_push.sv
dv/ring_buffer_checker.sv
dv/byte_ring_buffer_word_push_test.sv
